>>> rtl/bb3_pkg.sv
// bb3_pkg: shared types, sizes and register codes for the 3x3 box blur stream.
// No dependencies; every rtl module of the block imports it.
`timescale 1ns / 1ps

package bb3_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int HEIGHT_LIMIT = 4096;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(HEIGHT_LIMIT);
   localparam int HGT_W = $clog2(HEIGHT_LIMIT + 1);
   localparam int LIN_W = $clog2(MAX_WIDTH * HEIGHT_LIMIT);

   localparam int WIDTH_RESET  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int HEIGHT_RESET = 768;

   // configuration port
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 13;
   localparam int WIDTH_FIELD_W  = 11;
   localparam int HEIGHT_FIELD_W = 13;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   // line store lanes: one lane per row modulo three
   localparam int LANES  = 3;
   localparam int LANE_W = 2;

   // arithmetic
   localparam int CHAN_W = 8;
   localparam int SUM_W  = 12;
   localparam int CNT_W  = 4;
   localparam int DIV_W  = 13;

   typedef logic [2:0][CHAN_W-1:0] pixel_type;      // [2] red, [1] green, [0] blue
   typedef pixel_type [LANES-1:0] lanes_type;
   typedef logic [2:0][SUM_W-1:0] sum_type;

   typedef struct packed {
      logic              func;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              row_end;
      logic              frame_end;
   } rsp_item_type;

   typedef struct packed {
      logic              en;
      logic [LANE_W-1:0] lane;
      logic [COL_W-1:0]  addr;
      pixel_type         data;
   } line_wr_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
      sum_type          sum;
   } div_req_type;

   typedef struct packed {
      logic      done;
      pixel_type quot;
   } div_rsp_type;

endpackage

>>> rtl/bb3_line_ram.sv
// bb3_line_ram: line store, one word per column holding three row lanes.
// Lane write, registered read. Uses bb3_pkg.
`timescale 1ns / 1ps

module bb3_line_ram import bb3_pkg::*; (
   input  logic             clock,
   input  line_wr_type      wr,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   output lanes_type        rd_data
);

   lanes_type line_mem_ff [MAX_WIDTH];
   lanes_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         line_mem_ff[wr.addr][wr.lane] <= wr.data;
      end
   end

   // read returns the old word when the same column is written in that cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bb3_div.sv
// bb3_div: restoring divider, one quotient bit per cycle, three channels in step.
// Gives round-half-up mean (2*sum+count)/(2*count). Uses bb3_pkg.
`timescale 1ns / 1ps

module bb3_div import bb3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int STEP_W = $clog2(CHAN_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CHAN_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIV_W-1:0]  rem_ff [3];
   logic [DIV_W-1:0]  rem_in [3];
   logic [DIV_W-1:0]  dsh_ff;
   pixel_type         quot_ff;
   pixel_type         quot_in;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         if (rem_ff[ch] >= dsh_ff) begin
            rem_in[ch]  = rem_ff[ch] - dsh_ff;
            quot_in[ch] = {quot_ff[ch][CHAN_W-2:0], 1'b1};
         end else begin
            rem_in[ch]  = rem_ff[ch];
            quot_in[ch] = {quot_ff[ch][CHAN_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         for (int ch = 0; ch < 3; ch++) begin
            rem_ff[ch] <= DIV_W'({div_req.sum[ch], 1'b0}) + DIV_W'(div_req.count);
         end
         // divisor is 2*count, aligned to the top quotient bit
         dsh_ff <= DIV_W'({div_req.count, 1'b0}) << (CHAN_W - 1);
      end else if (busy_ff) begin
         for (int ch = 0; ch < 3; ch++) begin
            rem_ff[ch] <= rem_in[ch];
         end
         quot_ff <= quot_in;
         dsh_ff  <= dsh_ff >> 1;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

>>> rtl/box_blur_3x3_stream.sv
// box_blur_3x3_stream: 3x3 box blur of an RGB raster stream, two or three lines kept.
// Items are taken one at a time: a new item is accepted only in idle, after the last one
// has committed; an item that yields a result waits for three column reads of the line
// store and the 8-step divider, and its commit stalls while the output register is full.
// Reset (synchronous): width 1024, height 768, frame restarts; line store not cleared.
// Uses bb3_pkg, bb3_line_ram, bb3_div.
`timescale 1ns / 1ps

module box_blur_3x3_stream import bb3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int GOT_W = LIN_W + 1;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_EVAL   = 8'b0000_0010,
      S_RD0    = 8'b0000_0100,
      S_RD1    = 8'b0000_1000,
      S_RD2    = 8'b0001_0000,
      S_RD3    = 8'b0010_0000,
      S_DIV    = 8'b0100_0000,
      S_COMMIT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [WID_W-1:0]  width_ff;
   logic [HGT_W-1:0]  height_ff;
   logic [COL_W-1:0]  wm1;
   logic [ROW_W-1:0]  hm1;

   req_item_type      item_ff;
   logic              take_ff;
   pixel_type         cur_pix;

   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [LANE_W-1:0] in_lane_ff, in_lane_in;
   logic [LIN_W-1:0]  in_lin_ff, in_lin_in;
   logic              frame_in_ff, frame_in_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [LANE_W-1:0] out_lane_ff, out_lane_in;
   logic [LIN_W-1:0]  out_lin_ff, out_lin_in;

   logic [GOT_W-1:0]  need;
   logic [GOT_W-1:0]  got;
   logic              ready_now;
   logic              res_ff;
   logic [2:0]        fwd_ff;     // [2] row above, [1] output row, [0] row below
   logic [2:0]        rvalid_ff;
   logic [2:0]        fwd_now;
   logic [2:0]        rvalid_now;
   logic [LANE_W-1:0] lane_sel [3];

   logic              rd_en;
   logic [COL_W-1:0]  rd_col;
   logic              rd_cv;
   logic [COL_W-1:0]  rdq_col_ff;
   logic              rdq_cv_ff;
   lanes_type         rd_data;
   line_wr_type       line_wr;

   pixel_type         win_pix [3];
   logic [2:0]        win_use;
   sum_type           sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic              commit_go;
   logic              rsp_valid_ff;
   rsp_item_type      rsp_ff;
   logic              out_row_end;

   assign wm1     = COL_W'(width_ff - 1'b1);
   assign hm1     = ROW_W'(height_ff - 1'b1);
   assign cur_pix = {item_ff.red_in, item_ff.green_in, item_ff.blue_in};

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(WIDTH_RESET);
         height_ff <= HGT_W'(HEIGHT_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               if (csr_wdata[WIDTH_FIELD_W-1:0] == '0) begin
                  width_ff <= WID_W'(1);
               end else if (32'(csr_wdata[WIDTH_FIELD_W-1:0]) > MAX_WIDTH) begin
                  width_ff <= WID_W'(MAX_WIDTH);
               end else begin
                  width_ff <= WID_W'(csr_wdata[WIDTH_FIELD_W-1:0]);
               end
            end
            REG_IMAGE_HEIGHT: begin
               if (csr_wdata[HEIGHT_FIELD_W-1:0] == '0) begin
                  height_ff <= HGT_W'(1);
               end else if (32'(csr_wdata[HEIGHT_FIELD_W-1:0]) > HEIGHT_LIMIT) begin
                  height_ff <= HGT_W'(HEIGHT_LIMIT);
               end else begin
                  height_ff <= HGT_W'(csr_wdata[HEIGHT_FIELD_W-1:0]);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   assign req_ready = (state_ff == S_IDLE);
   assign commit_go = !res_ff || !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_EVAL;
         S_EVAL:   state_in = ready_now ? S_RD0 : S_COMMIT;
         S_RD0:    state_in = S_RD1;
         S_RD1:    state_in = S_RD2;
         S_RD2:    state_in = S_RD3;
         S_RD3:    state_in = S_DIV;
         S_DIV:    if (div_rsp.done) state_in = S_COMMIT;
         S_COMMIT: if (commit_go) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // an output is ready once its last in-image neighbor has arrived
   assign need = GOT_W'(out_lin_ff)
               + ((out_row_ff != hm1) ? GOT_W'(width_ff) : '0)
               + GOT_W'(out_col_ff != wm1);
   assign got       = GOT_W'(in_lin_ff) + GOT_W'(take_ff);
   assign ready_now = frame_in_ff || (need < got);

   assign fwd_now[2]    = ((ROW_W + 1)'(in_row_ff) + 1'b1) == (ROW_W + 1)'(out_row_ff);
   assign fwd_now[1]    = in_row_ff == out_row_ff;
   assign fwd_now[0]    = (ROW_W + 1)'(in_row_ff) == ((ROW_W + 1)'(out_row_ff) + 1'b1);
   assign rvalid_now[2] = out_row_ff != '0;
   assign rvalid_now[1] = 1'b1;
   assign rvalid_now[0] = out_row_ff != hm1;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= 1'b0;
      end else if (state_ff == S_EVAL) begin
         res_ff <= ready_now;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         item_ff <= req_payload;
         take_ff <= !req_payload.func && !frame_in_ff;
      end
      if (state_ff == S_EVAL) begin
         fwd_ff    <= fwd_now;
         rvalid_ff <= rvalid_now;
         sum_ff    <= '0;
         cnt_ff    <= '0;
      end else if (state_ff == S_RD1 || state_ff == S_RD2 || state_ff == S_RD3) begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
      if (rd_en) begin
         rdq_col_ff <= rd_col;
         rdq_cv_ff  <= rd_cv;
      end
   end

   // ---------------------------------------------------------------- line store access
   assign lane_sel[2] = (out_lane_ff == '0) ? LANE_W'(LANES - 1) : out_lane_ff - 1'b1;
   assign lane_sel[1] = out_lane_ff;
   assign lane_sel[0] = (out_lane_ff == LANE_W'(LANES - 1)) ? '0 : out_lane_ff + 1'b1;

   always_comb begin
      rd_en  = 1'b0;
      rd_col = out_col_ff;
      rd_cv  = 1'b1;
      case (state_ff)
         S_RD0: begin
            rd_en  = 1'b1;
            rd_col = out_col_ff - 1'b1;
            rd_cv  = out_col_ff != '0;
         end
         S_RD1: begin
            rd_en = 1'b1;
         end
         S_RD2: begin
            rd_en  = 1'b1;
            rd_col = out_col_ff + 1'b1;
            rd_cv  = out_col_ff != wm1;
         end
         default: begin
         end
      endcase
   end

   assign line_wr.en   = (state_ff == S_COMMIT) && commit_go && take_ff;
   assign line_wr.lane = in_lane_ff;
   assign line_wr.addr = in_col_ff;
   assign line_wr.data = cur_pix;

   bb3_line_ram u_line_ram (
      .clock   (clock),
      .wr      (line_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_col),
      .rd_data (rd_data)
   );

   // forward the pixel of this item: it is written only at commit
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (take_ff && fwd_ff[j] && rdq_col_ff == in_col_ff) begin
            win_pix[j] = cur_pix;
         end else begin
            win_pix[j] = rd_data[lane_sel[j]];
         end
         win_use[j] = rvalid_ff[j] && rdq_cv_ff;
      end
   end

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      for (int j = 0; j < 3; j++) begin
         if (win_use[j]) begin
            for (int ch = 0; ch < 3; ch++) begin
               sum_in[ch] = sum_in[ch] + SUM_W'(win_pix[j][ch]);
            end
            cnt_in = cnt_in + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- divider
   assign div_req.start = (state_ff == S_RD3);
   assign div_req.count = cnt_in;
   assign div_req.sum   = sum_in;

   bb3_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------------- position counters
   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_lane_in  = in_lane_ff;
      in_lin_in   = in_lin_ff;
      frame_in_in = frame_in_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_lane_in = out_lane_ff;
      out_lin_in  = out_lin_ff;
      if (state_ff == S_COMMIT && commit_go) begin
         if (take_ff) begin
            in_lin_in = in_lin_ff + 1'b1;
            if (in_col_ff == wm1) begin
               in_col_in = '0;
               if (in_row_ff == hm1) begin
                  in_row_in   = '0;
                  in_lane_in  = '0;
                  in_lin_in   = '0;
                  frame_in_in = 1'b1;
               end else begin
                  in_row_in  = in_row_ff + 1'b1;
                  in_lane_in = (in_lane_ff == LANE_W'(LANES - 1)) ? '0 : in_lane_ff + 1'b1;
               end
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
         end
         if (res_ff) begin
            out_lin_in = out_lin_ff + 1'b1;
            if (out_col_ff == wm1) begin
               out_col_in = '0;
               if (out_row_ff == hm1) begin
                  // last output of the frame: restart everything
                  out_row_in  = '0;
                  out_lane_in = '0;
                  out_lin_in  = '0;
                  in_col_in   = '0;
                  in_row_in   = '0;
                  in_lane_in  = '0;
                  in_lin_in   = '0;
                  frame_in_in = 1'b0;
               end else begin
                  out_row_in  = out_row_ff + 1'b1;
                  out_lane_in = (out_lane_ff == LANE_W'(LANES - 1)) ? '0 : out_lane_ff + 1'b1;
               end
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_lane_ff  <= '0;
         in_lin_ff   <= '0;
         frame_in_ff <= 1'b0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_lane_ff <= '0;
         out_lin_ff  <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_lane_ff  <= in_lane_in;
         in_lin_ff   <= in_lin_in;
         frame_in_ff <= frame_in_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_lane_ff <= out_lane_in;
         out_lin_ff  <= out_lin_in;
      end
   end

   // ---------------------------------------------------------------- output register
   assign out_row_end = out_col_ff == wm1;

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_COMMIT && res_ff && commit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_COMMIT && res_ff && commit_go) begin
         rsp_ff.red_out   <= div_rsp.quot[2];
         rsp_ff.green_out <= div_rsp.quot[1];
         rsp_ff.blue_out  <= div_rsp.quot[0];
         rsp_ff.row_end   <= out_row_end;
         rsp_ff.frame_end <= out_row_end && (out_row_ff == hm1);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------- checks
   a_frame_in_wrapped: assert property (@(posedge clock) disable iff (reset)
      frame_in_ff |-> (in_lin_ff == '0) && (in_col_ff == '0) && (in_row_ff == '0))
      else $error("input position not at frame start while frame is complete");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   a_columns_in_row: assert property (@(posedge clock) disable iff (reset)
      (in_col_ff <= wm1) && (out_col_ff <= wm1))
      else $error("column counter beyond image width");

   a_lanes_legal: assert property (@(posedge clock) disable iff (reset)
      (in_lane_ff != LANE_W'(LANES)) && (out_lane_ff != LANE_W'(LANES)))
      else $error("line lane counter out of range");

   a_result_after_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD0) |-> $past(state_ff == S_EVAL) && res_ff)
      else $error("column reads started for an item that yields no result");

endmodule
